FILE: hw/rtl/pft_pkg.sv
// ----------------------------------------------------------------------------
// pft_pkg
// Shared types and codes of the Pareto filter table.
// ----------------------------------------------------------------------------
package pft_pkg;

	localparam int unsigned DEPTH_DEF = 64;
	localparam int unsigned INF_W     = 31;
	localparam int unsigned OPT_W     = 32;
	localparam int unsigned COEF_W    = 24;
	localparam int unsigned CNT_W     = 7;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_QREF  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [1:0] REG_BETA  = 2'd0;
	localparam logic [1:0] REG_GAMMA = 2'd1;
	localparam logic [1:0] REG_MAXE  = 2'd2;

	localparam logic [COEF_W-1:0] BETA_RST  = 24'd16777048;
	localparam logic [COEF_W-1:0] GAMMA_RST = 24'd168;
	localparam logic [CNT_W-1:0]  MAXE_RST  = 7'd50;

	typedef struct packed {
		logic [INF_W-1:0]        infeas;
		logic signed [OPT_W-1:0] optim;
	} entry_t;

endpackage

FILE: hw/rtl/pft_mem.sv
// ----------------------------------------------------------------------------
// pft_mem
// Entry store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pft_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  pft_pkg::entry_t wr_data,
	input  logic [AW-1:0]   rd_addr,
	output pft_pkg::entry_t rd_data
);
	import pft_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: hw/rtl/pareto_filter_table.sv
// ----------------------------------------------------------------------------
// pareto_filter_table
// Bounded filter of (infeasibility, optimality) pairs with add, query,
// query against a reference pair, and clear.
// ----------------------------------------------------------------------------
// Usage: raise start with a word on opcode and the pair ports while busy is
// low; the word is taken at that edge and busy rises, but a clear finishes
// without leaving idle. When the operation ends, done pulses for one cycle
// with accepted, entry_count and bound_finite; the receiver cannot stall, so
// the result must be taken in that cycle.
// Steps: a query against a reference runs the decrease and envelope tests; a
// query checks the bound, scans for the slot and, unless it is first, runs
// the decrease test; an add compacts, checks capacity, evicts when full,
// scans, then shifts entries up and writes the new pair into its slot.
// All list work goes through the single read and single write port of the
// entry memory; one shared 24x31 multiplier serves every envelope and
// decrease test. The configuration port writes beta, gamma and max_entries;
// the user writes them only while idle; the block itself does not enforce it.
// Reset empties the list, makes the bound infinite and restores the
// register defaults; no memory sweep is needed.
// ----------------------------------------------------------------------------
module pareto_filter_table #(
	parameter int unsigned DEPTH = pft_pkg::DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      opcode,
	input  logic [pft_pkg::INF_W-1:0]       trial_infeas,
	input  logic signed [pft_pkg::OPT_W-1:0] trial_optim,
	input  logic [pft_pkg::INF_W-1:0]       ref_infeas,
	input  logic signed [pft_pkg::OPT_W-1:0] ref_optim,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [pft_pkg::COEF_W-1:0]      cfg_data,
	output logic                            done,
	output logic                            accepted,
	output logic [pft_pkg::CNT_W-1:0]       entry_count,
	output logic                            bound_finite
);
	import pft_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned KW = (CW > CNT_W) ? CW : CNT_W;
	localparam int unsigned PW = COEF_W + INF_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CMP  = 4'd1;
	localparam logic [3:0] S_EVCK = 4'd2;
	localparam logic [3:0] S_EVMU = 4'd3;
	localparam logic [3:0] S_SCRD = 4'd4;
	localparam logic [3:0] S_SCCM = 4'd5;
	localparam logic [3:0] S_SHRD = 4'd6;
	localparam logic [3:0] S_SHWR = 4'd7;
	localparam logic [3:0] S_QBND = 4'd8;
	localparam logic [3:0] S_SUFF = 4'd9;
	localparam logic [3:0] S_Q2A  = 4'd10;
	localparam logic [3:0] S_Q2B  = 4'd11;

	logic [3:0]              state_q;
	logic [COEF_W-1:0]       beta_q, gamma_q;
	logic [CNT_W-1:0]        maxe_q;
	logic [CW-1:0]           fill_q, idx_q, w_q, pos_q;
	logic                    pend_q, fin_q, acc_q, done_q, worse_q, is_add_q;
	logic [INF_W-1:0]        bound_q, tinf_q, rinf_q;
	logic signed [OPT_W-1:0] topt_q, ropt_q, prev_q;

	logic               wr_en;
	logic [AW-1:0]      wr_addr, rd_addr;
	entry_t             wr_data, rd;
	logic [COEF_W-1:0]  mul_a;
	logic [INF_W-1:0]   mul_b, base;
	logic [PW-1:0]      prod, shl;
	logic [KW-1:0]      cap, fill_k;
	logic               dom, below, suff;
	logic signed [OPT_W:0] diff;

	pft_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd)
	);

	assign shl    = {tinf_q, {COEF_W{1'b0}}};
	assign prod   = PW'(mul_a) * PW'(mul_b);
	assign below  = shl < prod;
	assign dom    = (tinf_q < rd.infeas) && (topt_q <= rd.optim);
	assign base   = (fin_q && bound_q > rd.infeas) ? bound_q : rd.infeas;
	assign fill_k = KW'(fill_q);
	assign diff   = (state_q == S_Q2A) ? ((OPT_W+1)'(ropt_q) - (OPT_W+1)'(topt_q))
	                                   : ((OPT_W+1)'(prev_q) - (OPT_W+1)'(topt_q));
	assign suff   = !diff[OPT_W] &&
	                ({diff[OPT_W-1:0], {COEF_W{1'b0}}} >= (OPT_W+COEF_W)'(prod));

	always_comb begin
		if (maxe_q == '0) begin
			cap = KW'(1);
		end else if (KW'(maxe_q) > KW'(DEPTH)) begin
			cap = KW'(DEPTH);
		end else begin
			cap = KW'(maxe_q);
		end
	end

	always_comb begin
		mul_a = beta_q;
		mul_b = rd.infeas;
		unique case (state_q)
			S_EVMU: mul_b = base;
			S_QBND: mul_b = bound_q;
			S_SUFF, S_Q2A: begin
				mul_a = gamma_q;
				mul_b = tinf_q;
			end
			S_Q2B: mul_b = rinf_q;
			default: mul_b = rd.infeas;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = w_q[AW-1:0];
		wr_data = rd;
		rd_addr = idx_q[AW-1:0];
		unique case (state_q)
			S_CMP: wr_en = pend_q && !dom;
			S_EVCK: rd_addr = AW'(fill_q - CW'(1));
			S_SHRD: begin
				rd_addr = AW'(idx_q - CW'(1));
				if (idx_q == pos_q) begin
					wr_en        = 1'b1;
					wr_addr      = pos_q[AW-1:0];
					wr_data.infeas = tinf_q;
					wr_data.optim  = topt_q;
				end
			end
			S_SHWR: begin
				wr_en   = 1'b1;
				wr_addr = idx_q[AW-1:0];
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q <= BETA_RST;
			gamma_q <= GAMMA_RST;
			maxe_q <= MAXE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BETA:  beta_q <= cfg_data;
				REG_GAMMA: gamma_q <= cfg_data;
				REG_MAXE:  maxe_q <= cfg_data[CNT_W-1:0];
				default:   maxe_q <= maxe_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			tinf_q <= trial_infeas;
			topt_q <= trial_optim;
			rinf_q <= ref_infeas;
			ropt_q <= ref_optim;
		end
		if (state_q == S_SCCM && !below) begin
			prev_q <= rd.optim;
		end
		if (state_q == S_Q2A) begin
			worse_q <= !suff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			idx_q    <= '0;
			w_q      <= '0;
			pos_q    <= '0;
			pend_q   <= 1'b0;
			fin_q    <= 1'b0;
			bound_q  <= '0;
			acc_q    <= 1'b0;
			done_q   <= 1'b0;
			is_add_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						idx_q    <= '0;
						w_q      <= '0;
						pend_q   <= 1'b0;
						is_add_q <= (opcode == OP_ADD);
						unique case (opcode)
							OP_ADD:   state_q <= S_CMP;
							OP_QUERY: state_q <= S_QBND;
							OP_QREF:  state_q <= S_Q2A;
							OP_CLEAR: begin
								fill_q  <= '0;
								bound_q <= '0;
								fin_q   <= 1'b0;
								acc_q   <= 1'b1;
								done_q  <= 1'b1;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_CMP: begin
					pend_q <= idx_q < fill_q;
					if (idx_q < fill_q) begin
						idx_q <= idx_q + CW'(1);
					end
					if (pend_q && !dom) begin
						w_q <= w_q + CW'(1);
					end
					if (!(idx_q < fill_q) && !pend_q) begin
						fill_q  <= w_q;
						state_q <= S_EVCK;
					end
				end
				S_EVCK: begin
					idx_q <= '0;
					if (fill_k >= cap && fill_q != '0) begin
						state_q <= S_EVMU;
					end else begin
						state_q <= S_SCRD;
					end
				end
				S_EVMU: begin
					bound_q <= prod[PW-1:COEF_W];
					fin_q   <= 1'b1;
					fill_q  <= fill_q - CW'(1);
					state_q <= S_SCRD;
				end
				S_QBND: begin
					if (fin_q && !(shl < prod)) begin
						acc_q   <= 1'b0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SCRD;
					end
				end
				S_SCRD: begin
					if (idx_q < fill_q) begin
						state_q <= S_SCCM;
					end else begin
						pos_q <= idx_q;
						if (is_add_q) begin
							idx_q   <= fill_q;
							state_q <= S_SHRD;
						end else if (idx_q == '0) begin
							acc_q   <= 1'b1;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_SUFF;
						end
					end
				end
				S_SCCM: begin
					if (below) begin
						pos_q <= idx_q;
						if (is_add_q) begin
							idx_q   <= fill_q;
							state_q <= S_SHRD;
						end else if (idx_q == '0) begin
							acc_q   <= 1'b1;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_SUFF;
						end
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_SCRD;
					end
				end
				S_SHRD: begin
					if (idx_q == pos_q) begin
						fill_q  <= fill_q + CW'(1);
						acc_q   <= 1'b1;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SHWR;
					end
				end
				S_SHWR: begin
					idx_q   <= idx_q - CW'(1);
					state_q <= S_SHRD;
				end
				S_SUFF: begin
					acc_q   <= suff;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_Q2A: state_q <= S_Q2B;
				S_Q2B: begin
					acc_q   <= !(worse_q && (shl > prod));
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy         = state_q != S_IDLE;
	assign done         = done_q;
	assign accepted     = acc_q;
	assign entry_count  = fill_k[CNT_W-1:0];
	assign bound_finite = fin_q;

endmodule

FILE: verif/pft_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pft_checker
// Watches the command, configuration and result channels of the Pareto
// filter table. It keeps its own copy of the filter list, the upper bound and
// the registers, works out the result of each accepted word, and compares
// every done pulse with the oldest expectation, field by field.
// ----------------------------------------------------------------------------
module pft_checker
	import pft_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic [1:0]               opcode,
	input  logic [INF_W-1:0]         trial_infeas,
	input  logic signed [OPT_W-1:0]  trial_optim,
	input  logic [INF_W-1:0]         ref_infeas,
	input  logic signed [OPT_W-1:0]  ref_optim,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [COEF_W-1:0]        cfg_data,
	input  logic                     done,
	input  logic                     accepted,
	input  logic [CNT_W-1:0]         entry_count,
	input  logic                     bound_finite,
	output int                       outstanding,
	output int                       failures
);

	localparam longint SCL = 64'd16777216;

	typedef struct {
		bit            acc;
		bit [CNT_W-1:0] cnt;
		bit            fin;
	} verdict_t;

	verdict_t  pending_q[$];
	bit [COEF_W-1:0] beta_r, gamma_r;
	bit [CNT_W-1:0]  maxe_r;
	longint    filt_inf[DEPTH_DEF];
	longint    filt_opt[DEPTH_DEF];
	int        fill;
	longint    bound_val;
	bit        bound_fin;
	int        seen;

	function automatic bit below_env(longint x, longint e);
		return x * SCL < longint'(beta_r) * e;
	endfunction

	function automatic bit enough_decrease(longint opt, longint prev, longint inf);
		return opt * SCL <= prev * SCL - longint'(gamma_r) * inf;
	endfunction

	function automatic int insert_slot(longint inf);
		int p;
		p = 0;
		while (p < fill && !below_env(inf, filt_inf[p]))
			p++;
		return p;
	endfunction

	function automatic void add_pair(longint inf, longint opt);
		int w, cap, p;
		longint base;
		w = 0;
		for (int i = 0; i < fill; i++) begin
			if (inf < filt_inf[i] && opt <= filt_opt[i])
				continue;
			filt_inf[w] = filt_inf[i];
			filt_opt[w] = filt_opt[i];
			w++;
		end
		fill = w;
		cap = int'(maxe_r);
		if (cap < 1) cap = 1;
		if (cap > DEPTH_DEF) cap = DEPTH_DEF;
		if (fill >= cap && fill > 0) begin
			base = filt_inf[fill-1];
			if (bound_fin && bound_val > base) base = bound_val;
			bound_val = ((longint'(beta_r) * base) >>> 24) & 64'h7FFF_FFFF;
			bound_fin = 1;
			fill--;
		end
		p = insert_slot(inf);
		for (int i = fill; i > p; i--) begin
			filt_inf[i] = filt_inf[i-1];
			filt_opt[i] = filt_opt[i-1];
		end
		filt_inf[p] = inf;
		filt_opt[p] = opt;
		fill++;
	endfunction

	function automatic bit query_pair(longint inf, longint opt);
		int p;
		if (bound_fin && longint'(beta_r) * bound_val <= inf * SCL)
			return 0;
		p = insert_slot(inf);
		if (p == 0)
			return 1;
		return enough_decrease(opt, filt_opt[p-1], inf);
	endfunction

	function automatic verdict_t predict_word(bit [1:0] op, longint ti, longint to,
		longint ri, longint ro);
		verdict_t v;
		bit worse, wider;
		v.acc = 1;
		case (op)
			OP_ADD: add_pair(ti, to);
			OP_QUERY: v.acc = query_pair(ti, to);
			OP_QREF: begin
				worse = !enough_decrease(to, ro, ti);
				wider = ti * SCL > longint'(beta_r) * ri;
				v.acc = !(worse && wider);
			end
			default: begin
				fill = 0;
				bound_val = 0;
				bound_fin = 0;
			end
		endcase
		v.cnt = fill[CNT_W-1:0];
		v.fin = bound_fin;
		return v;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch at result %0d: %s got %0d expected %0d", seen, what, got, want);
		failures++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t w;
		if (!arst_n) begin
			beta_r = BETA_RST;
			gamma_r = GAMMA_RST;
			maxe_r = MAXE_RST;
			fill = 0;
			bound_val = 0;
			bound_fin = 0;
			pending_q.delete();
			failures = 0;
			seen = 0;
		end else begin
			if (done) begin
				if (pending_q.size() == 0) begin
					$display("result word with nothing pending at result %0d", seen);
					failures++;
				end else begin
					w = pending_q.pop_front();
					if (accepted !== w.acc)
						report("accepted", longint'(accepted), longint'(w.acc));
					if (entry_count !== w.cnt)
						report("entry_count", longint'(entry_count), longint'(w.cnt));
					if (bound_finite !== w.fin)
						report("bound_finite", longint'(bound_finite), longint'(w.fin));
				end
				seen++;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_BETA: beta_r = cfg_data;
					REG_GAMMA: gamma_r = cfg_data;
					REG_MAXE: maxe_r = cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy)
				pending_q.push_back(predict_word(opcode, longint'(trial_infeas),
					longint'(trial_optim), longint'(ref_infeas), longint'(ref_optim)));
		end
		outstanding = pending_q.size();
	end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the Pareto filter table with directed and random words over several
// register settings, with random gaps and pauses, and gives the verdict from
// the failure count of the checker.
// ----------------------------------------------------------------------------
module testbench;
	import pft_pkg::*;

	logic                    clk = 0;
	logic                    arst_n = 0;
	logic                    start = 0;
	logic                    busy;
	logic [1:0]              opcode = OP_CLEAR;
	logic [INF_W-1:0]        trial_infeas = '0;
	logic signed [OPT_W-1:0] trial_optim = '0;
	logic [INF_W-1:0]        ref_infeas = '0;
	logic signed [OPT_W-1:0] ref_optim = '0;
	logic                    cfg_we = 0;
	logic [1:0]              cfg_index = REG_BETA;
	logic [COEF_W-1:0]       cfg_data = '0;
	logic                    done, accepted, bound_finite;
	logic [CNT_W-1:0]        entry_count;
	int                      outstanding, failures;
	bit                      gaps_on;

	always #1 clk = ~clk;

	pareto_filter_table i_dut (.*);

	pft_checker i_chk (.*);

	task automatic send_word(logic [1:0] op, logic [INF_W-1:0] ti, logic [OPT_W-1:0] to,
		logic [INF_W-1:0] ri, logic [OPT_W-1:0] ro);
		if (gaps_on && $urandom_range(99) < 35) begin
			start <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1;
		opcode <= op;
		trial_infeas <= ti;
		trial_optim <= to;
		ref_infeas <= ri;
		ref_optim <= ro;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [COEF_W-1:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	function automatic logic [INF_W-1:0] rand_infeas();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3: return INF_W'($urandom);
			default: return INF_W'($urandom_range(0, 32'h0004_0000));
		endcase
	endfunction

	function automatic logic [OPT_W-1:0] rand_optim();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2, 3: return $urandom;
			default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
		endcase
	endfunction

	task automatic random_words(int n);
		int r;
		logic [1:0] op;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			op = r < 45 ? OP_ADD : r < 78 ? OP_QUERY : r < 97 ? OP_QREF : OP_CLEAR;
			send_word(op, rand_infeas(), rand_optim(), rand_infeas(), rand_optim());
		end
	endtask

	initial begin
		#20000000;
		$display("testbench failed");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_word(OP_QUERY, '0, '0, '0, '0);
		send_word(OP_ADD, '0, 32'h7FFF_FFFF, '0, '0);
		send_word(OP_ADD, '1, 32'h8000_0000, '0, '0);
		send_word(OP_ADD, 31'h0001_0000, '0, '0, '0);
		send_word(OP_QUERY, 31'h0000_8000, 32'h8000_0000, '0, '0);
		send_word(OP_QUERY, '1, 32'h7FFF_FFFF, '0, '0);
		send_word(OP_QREF, 31'h0001_0000, 32'h0001_0000, 31'h0001_0000, 32'h0001_0000);
		send_word(OP_QREF, '1, 32'h7FFF_FFFF, '0, 32'h8000_0000);
		send_word(OP_QREF, '0, 32'h8000_0000, '1, 32'h7FFF_FFFF);
		send_word(OP_ADD, 31'h0000_1000, 32'h8000_0000, '0, '0);
		send_word(OP_CLEAR, '1, '1, '1, '1);
		drain();

		write_reg(REG_MAXE, '0);
		send_word(OP_ADD, 31'h0002_0000, 32'd100, '0, '0);
		send_word(OP_ADD, 31'h0003_0000, 32'd50, '0, '0);
		send_word(OP_ADD, 31'h0001_0000, 32'd200, '0, '0);
		send_word(OP_QUERY, 31'h0004_0000, '0, '0, '0);
		send_word(OP_QUERY, 31'h0000_1000, '0, '0, '0);
		send_word(OP_CLEAR, '0, '0, '0, '0);
		drain();

		gaps_on = 1;
		random_words(150);
		drain();

		write_reg(REG_BETA, '1);
		write_reg(REG_GAMMA, '0);
		write_reg(REG_MAXE, 24'd127);
		random_words(150);
		drain();

		write_reg(REG_MAXE, 24'd3);
		write_reg(REG_BETA, '0);
		write_reg(REG_GAMMA, '1);
		gaps_on = 0;
		random_words(100);
		drain();

		write_reg(REG_BETA, COEF_W'($urandom));
		write_reg(REG_GAMMA, COEF_W'($urandom_range(0, 4096)));
		write_reg(REG_MAXE, 24'd64);
		gaps_on = 1;
		random_words(200);
		drain();

		repeat (300) @(posedge clk);
		if (failures == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/pft_pkg.sv
hw/rtl/pft_mem.sv
hw/rtl/pareto_filter_table.sv
verif/pft_checker.sv
verif/testbench.sv
